// File: sv/frba_pkg.sv
// Shared types and constants for the fenced ring buffer allocator.
// No dependencies; every other file refers to this package by scoped names.
package frba_pkg;

   localparam int RING_W    = 27;  // ring size register and request byte count
   localparam int FENCE_W   = 64;
   localparam int STATUS_W  = 3;
   localparam int OFF_OUT_W = 26;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_WRAP_BLK = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OVERLAP  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_QFULL    = 3'd5;

   // Classified request handed from the front end to the allocation engine.
   typedef struct packed {
      logic [RING_W-1:0]  request_bytes;
      logic [FENCE_W-1:0] current_fence;
      logic [FENCE_W-1:0] completed_fence;
      logic               do_reclaim;
      logic               bad_size;
   } cmd_type;

endpackage

// File: sv/frba_front.sv
// Request front end: accepts requests, tracks the last seen completed fence and
// classifies each request before it is queued. Depends on frba_pkg.
module frba_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [frba_pkg::RING_W-1:0]       req_request_bytes,
   input  logic [frba_pkg::FENCE_W-1:0]      req_current_fence,
   input  logic [frba_pkg::FENCE_W-1:0]      req_completed_fence,
   input  logic [frba_pkg::RING_W-1:0]       ring_size,
   input  logic                              queue_full,
   output logic                              push,
   output frba_pkg::cmd_type                 push_cmd
);

   logic [frba_pkg::FENCE_W-1:0] last_seen_ff, last_seen_in;
   logic                         newer;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign newer     = req_completed_fence > last_seen_ff;

   always_comb begin
      last_seen_in = last_seen_ff;
      if (push && newer) begin
         last_seen_in = req_completed_fence;
      end
   end

   always_comb begin
      push_cmd.request_bytes   = req_request_bytes;
      push_cmd.current_fence   = req_current_fence;
      push_cmd.completed_fence = req_completed_fence;
      push_cmd.do_reclaim      = newer;
      push_cmd.bad_size        = (req_request_bytes == '0) || (ring_size == '0) ||
                                 (req_request_bytes > ring_size);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_ff <= '0;
      end else begin
         last_seen_ff <= last_seen_in;
      end
   end

endmodule

// File: sv/frba_fifo.sv
// Two-entry command queue between the front end and the allocation engine.
// Depends on frba_pkg for the command type.
module frba_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  frba_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output frba_pkg::cmd_type head_cmd
);

   frba_pkg::cmd_type slot_ff [2];
   logic              wr_idx_ff, wr_idx_in;
   logic              rd_idx_ff, rd_idx_in;
   logic [1:0]        fill_ff, fill_in;

   assign full     = fill_ff == 2'd2;
   assign valid    = fill_ff != 2'd0;
   assign head_cmd = slot_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = push ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = pop ? ~rd_idx_ff : rd_idx_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: sv/frba_rem.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one dividend bit
// per cycle. Used for the head update on reclaim. Depends on frba_pkg.
module frba_rem #(
   parameter int DVD_W = 28
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DVD_W-1:0]            dividend,
   input  logic [frba_pkg::RING_W-1:0] divisor,
   output logic                        done,
   output logic [frba_pkg::RING_W-1:0] remainder
);

   localparam int RW    = frba_pkg::RING_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW:0]      trial;
   logic [RW:0]      trial_diff;

   assign done      = done_ff;
   assign remainder = rem_ff;

   // rem_ff stays below divisor, so the trial difference fits in RW bits
   assign trial      = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? trial_diff[RW-1:0] : trial[RW-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: sv/frba_back.sv
// Allocation engine: reclaims completed fence entries, allocates at the tail,
// keeps the pending fence queue memory and the result register.
// Depends on frba_pkg and frba_rem.
module frba_back #(
   parameter int PENDING_ENTRIES = 16,
   parameter int OFFSET_BITS     = 27
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ring_clear,
   input  logic [frba_pkg::RING_W-1:0]         ring_size,
   input  logic                                cmd_valid,
   input  frba_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [frba_pkg::STATUS_W-1:0]       rsp_status,
   output logic [frba_pkg::OFF_OUT_W-1:0]      rsp_offset,
   output logic [frba_pkg::FENCE_W-1:0]        rsp_oldest_fence
);

   localparam int RW     = frba_pkg::RING_W;
   localparam int FW     = frba_pkg::FENCE_W;
   localparam int POS_W  = OFFSET_BITS;
   localparam int WIDE_W = ((OFFSET_BITS > RW) ? OFFSET_BITS : RW) + 1;
   localparam int PTR_W  = $clog2(PENDING_ENTRIES);
   localparam int CNT_W  = $clog2(PENDING_ENTRIES + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RCL_RD  = 4'd1;
   localparam logic [3:0] S_RCL_CHK = 4'd2;
   localparam logic [3:0] S_RCL_MOD = 4'd3;
   localparam logic [3:0] S_RCL_DIV = 4'd4;
   localparam logic [3:0] S_ALLOC   = 4'd5;
   localparam logic [3:0] S_PAD     = 4'd6;
   localparam logic [3:0] S_CHECK   = 4'd7;
   localparam logic [3:0] S_COMMIT  = 4'd8;
   localparam logic [3:0] S_FIN_RD  = 4'd9;
   localparam logic [3:0] S_FIN_OUT = 4'd10;

   logic [3:0]                       state_ff, state_in;
   frba_pkg::cmd_type                cmd_ff, cmd_in;
   logic [RW-1:0]                    head_ff, head_in;
   logic [POS_W-1:0]                 tail_ff, tail_in;
   logic [POS_W-1:0]                 used_ff, used_in;
   logic [POS_W-1:0]                 pad_ff, pad_in;
   logic [PTR_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                 newest_slot_ff, newest_slot_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [FW-1:0]                    newest_key_ff, newest_key_in;
   logic [POS_W-1:0]                 newest_bytes_ff, newest_bytes_in;
   logic [WIDE_W-1:0]                dvd_ff, dvd_in;
   logic [frba_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [frba_pkg::OFF_OUT_W-1:0]   offset_ff, offset_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [frba_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [frba_pkg::OFF_OUT_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [FW-1:0]                    rsp_oldest_ff, rsp_oldest_in;

   // pending fence queue
   logic [FW-1:0]                    key_mem   [PENDING_ENTRIES];
   logic [POS_W-1:0]                 bytes_mem [PENDING_ENTRIES];
   logic [FW-1:0]                    rd_key_ff;
   logic [POS_W-1:0]                 rd_bytes_ff;
   logic                             wr_en;
   logic [PTR_W-1:0]                 wr_addr;
   logic [POS_W-1:0]                 wr_bytes;

   logic                             charge_en;
   logic [POS_W-1:0]                 charge_bytes;
   logic [POS_W-1:0]                 merged_bytes;
   logic                             merges;
   logic                             can_charge;

   logic [WIDE_W-1:0]                ring_w, tail_w, head_w, count_w, used_w;
   logic [WIDE_W-1:0]                tail_end, dvd_diff;
   logic                             rem_start;
   logic                             rem_done;
   logic [RW-1:0]                    rem_value;

   frba_rem #(
      .DVD_W (WIDE_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (dvd_ff),
      .divisor   (ring_size),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_offset       = rsp_offset_ff;
   assign rsp_oldest_fence = rsp_oldest_ff;

   assign ring_w   = WIDE_W'(ring_size);
   assign tail_w   = WIDE_W'(tail_ff);
   assign head_w   = WIDE_W'(head_ff);
   assign count_w  = WIDE_W'(cmd_ff.request_bytes);
   assign used_w   = WIDE_W'(used_ff);
   assign tail_end = tail_w + count_w;
   assign dvd_diff = dvd_ff - ring_w;

   // merging only looks at the newest queued entry
   assign merges       = (count_ff != '0) && (newest_key_ff == cmd_ff.current_fence);
   assign can_charge   = merges || (count_ff < CNT_W'(PENDING_ENTRIES));
   assign merged_bytes = newest_bytes_ff + charge_bytes;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      pad_in        = pad_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      dvd_in        = dvd_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_oldest_in = rsp_oldest_ff;
      cmd_pop       = 1'b0;
      rem_start     = 1'b0;
      charge_en     = 1'b0;
      charge_bytes  = POS_W'(cmd_ff.request_bytes);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               status_in = frba_pkg::STAT_OK;
               offset_in = '0;
               state_in  = cmd.do_reclaim ? S_RCL_RD : S_ALLOC;
            end
         end
         S_RCL_RD: begin
            // read data for rd_ptr_ff is ready next cycle
            state_in = (count_ff == '0) ? S_ALLOC : S_RCL_CHK;
         end
         S_RCL_CHK: begin
            if (rd_key_ff > cmd_ff.completed_fence) begin
               state_in = S_ALLOC;
            end else begin
               used_in   = (rd_bytes_ff > used_ff) ? '0 : (used_ff - rd_bytes_ff);
               rd_ptr_in = (rd_ptr_ff == PTR_W'(PENDING_ENTRIES - 1)) ? '0 :
                           (rd_ptr_ff + 1'b1);
               count_in  = count_ff - 1'b1;
               if (ring_size == '0) begin
                  head_in  = '0;
                  state_in = S_RCL_RD;
               end else begin
                  dvd_in   = head_w + WIDE_W'(rd_bytes_ff);
                  state_in = S_RCL_MOD;
               end
            end
         end
         S_RCL_MOD: begin
            // a sum below twice the ring size needs at most one subtraction; else long division
            if (dvd_ff < ring_w) begin
               head_in  = RW'(dvd_ff);
               state_in = S_RCL_RD;
            end else if (dvd_diff < ring_w) begin
               head_in  = RW'(dvd_diff);
               state_in = S_RCL_RD;
            end else begin
               rem_start = 1'b1;
               state_in  = S_RCL_DIV;
            end
         end
         S_RCL_DIV: begin
            if (rem_done) begin
               head_in  = rem_value;
               state_in = S_RCL_RD;
            end
         end
         S_ALLOC: begin
            if (cmd_ff.bad_size) begin
               status_in = frba_pkg::STAT_BAD_SIZE;
               state_in  = S_FIN_RD;
            end else if (tail_end > ring_w) begin
               if (head_ff == '0) begin
                  status_in = frba_pkg::STAT_WRAP_BLK;
                  state_in  = S_FIN_RD;
               end else if (!can_charge) begin
                  status_in = frba_pkg::STAT_QFULL;
                  state_in  = S_FIN_RD;
               end else begin
                  pad_in   = (ring_w > tail_w) ? POS_W'(ring_w - tail_w) : '0;
                  state_in = S_PAD;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_PAD: begin
            // padding to the ring end stays charged whatever follows
            charge_en    = 1'b1;
            charge_bytes = pad_ff;
            used_in      = used_ff + pad_ff;
            tail_in      = '0;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (used_w + count_w > ring_w) begin
               status_in = frba_pkg::STAT_FULL;
               state_in  = S_FIN_RD;
            end else if ((tail_w < head_w) && (tail_end > head_w)) begin
               status_in = frba_pkg::STAT_OVERLAP;
               state_in  = S_FIN_RD;
            end else if (!can_charge) begin
               status_in = frba_pkg::STAT_QFULL;
               state_in  = S_FIN_RD;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            charge_en = 1'b1;
            offset_in = frba_pkg::OFF_OUT_W'(tail_w);
            tail_in   = POS_W'(tail_end);
            used_in   = POS_W'(used_w + count_w);
            status_in = frba_pkg::STAT_OK;
            state_in  = S_FIN_RD;
         end
         S_FIN_RD: begin
            // lets the queue read catch up with the last write
            state_in = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = offset_ff;
               rsp_oldest_in = (count_ff != '0) ? rd_key_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // charge bytes to the newest entry or push a new one
   always_comb begin
      wr_ptr_in       = wr_ptr_ff;
      newest_slot_in  = newest_slot_ff;
      newest_key_in   = newest_key_ff;
      newest_bytes_in = newest_bytes_ff;
      wr_en           = 1'b0;
      wr_addr         = wr_ptr_ff;
      wr_bytes        = charge_bytes;
      if (charge_en) begin
         wr_en = 1'b1;
         if (merges) begin
            wr_addr         = newest_slot_ff;
            wr_bytes        = merged_bytes;
            newest_bytes_in = merged_bytes;
         end else begin
            newest_slot_in  = wr_ptr_ff;
            newest_key_in   = cmd_ff.current_fence;
            newest_bytes_in = charge_bytes;
            wr_ptr_in       = (wr_ptr_ff == PTR_W'(PENDING_ENTRIES - 1)) ? '0 :
                              (wr_ptr_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= cmd_ff.current_fence;
         bytes_mem[wr_addr] <= wr_bytes;
      end
      rd_key_ff   <= key_mem[rd_ptr_ff];
      rd_bytes_ff <= bytes_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      pad_ff          <= pad_in;
      dvd_ff          <= dvd_in;
      status_ff       <= status_in;
      offset_ff       <= offset_in;
      newest_slot_ff  <= newest_slot_in;
      newest_key_ff   <= newest_key_in;
      newest_bytes_ff <= newest_bytes_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_oldest_ff   <= rsp_oldest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_clear) begin
            head_ff   <= '0;
            tail_ff   <= '0;
            used_ff   <= '0;
            rd_ptr_ff <= '0;
            wr_ptr_ff <= '0;
            count_ff  <= '0;
         end else begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            used_ff   <= used_in;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            count_ff  <= count_in + CNT_W'(charge_en && !merges);
         end
      end
   end

endmodule

// File: sv/fenced_ring_buffer_allocator.sv
// Fenced ring buffer allocator top level: ring size register, front end,
// command queue and allocation engine. Depends on frba_pkg and all frba_ modules.
//
//  port group  dir  handshake            payload
//  req_*       in   req_valid/req_stall  request_bytes, current_fence, completed_fence
//  rsp_*       out  rsp_valid/rsp_stall  status, offset, oldest_fence
//  csr_*       in   csr_write_enable     write_data (ring size; write empties the ring)
//
// A granted item passes S_ALLOC, S_CHECK, S_COMMIT, S_FIN_RD and S_FIN_OUT, with S_PAD
// when the allocation wraps; a failed check skips to S_FIN_RD. Reclaim retires each
// fence entry via S_RCL_RD, S_RCL_CHK and S_RCL_MOD (no S_RCL_MOD with a zero ring); a
// head update whose sum reaches twice the ring size uses the bit-serial remainder unit.
// Up to two requests queue ahead. Synchronous active-high reset; the fence queue memory
// is not cleared. rsp_stall only holds the result register; the engine works up to it.
module fenced_ring_buffer_allocator #(
   parameter int PENDING_ENTRIES = 16,
   parameter int OFFSET_BITS     = 27
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [frba_pkg::RING_W-1:0]         req_request_bytes,
   input  logic [frba_pkg::FENCE_W-1:0]        req_current_fence,
   input  logic [frba_pkg::FENCE_W-1:0]        req_completed_fence,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [frba_pkg::STATUS_W-1:0]       rsp_status,
   output logic [frba_pkg::OFF_OUT_W-1:0]      rsp_offset,
   output logic [frba_pkg::FENCE_W-1:0]        rsp_oldest_fence,
   input  logic                                csr_write_enable,
   input  logic [frba_pkg::RING_W-1:0]         csr_write_data
);

   logic [frba_pkg::RING_W-1:0] ring_size_ff, ring_size_in;
   logic                        push;
   frba_pkg::cmd_type           push_cmd;
   logic                        queue_full;
   logic                        queue_valid;
   frba_pkg::cmd_type           queue_cmd;
   logic                        queue_pop;

   assign ring_size_in = csr_write_enable ? csr_write_data : ring_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= '0;
      end else begin
         ring_size_ff <= ring_size_in;
      end
   end

   frba_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_request_bytes   (req_request_bytes),
      .req_current_fence   (req_current_fence),
      .req_completed_fence (req_completed_fence),
      .ring_size           (ring_size_ff),
      .queue_full          (queue_full),
      .push                (push),
      .push_cmd            (push_cmd)
   );

   frba_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .head_cmd (queue_cmd)
   );

   frba_back #(
      .PENDING_ENTRIES (PENDING_ENTRIES),
      .OFFSET_BITS     (OFFSET_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .ring_clear       (csr_write_enable),
      .ring_size        (ring_size_ff),
      .cmd_valid        (queue_valid),
      .cmd              (queue_cmd),
      .cmd_pop          (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_offset       (rsp_offset),
      .rsp_oldest_fence (rsp_oldest_fence)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("command queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_valid)
      else $error("command queue read while empty");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= frba_pkg::STAT_QFULL))
      else $error("result status out of range");

   a_failed_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != frba_pkg::STAT_OK)) |-> (rsp_offset == '0))
      else $error("failed allocation reports a nonzero offset");

endmodule

// File: bench/fenced_ring_buffer_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fenced_ring_buffer_allocator: a scoreboard class predicts every
// response from its own copy of ring and fence-queue state. Needs frba_pkg and the RTL.
module fenced_ring_buffer_allocator_tb;

   localparam int RING_W          = frba_pkg::RING_W;
   localparam int FENCE_W         = frba_pkg::FENCE_W;
   localparam int STATUS_W        = frba_pkg::STATUS_W;
   localparam int OFF_OUT_W       = frba_pkg::OFF_OUT_W;
   localparam int QUEUE_DEPTH     = 16;
   localparam int WATCHDOG_CYCLES = 5000;  // reclaim of a full queue through the slow modulo
   localparam int SETTLE_CYCLES   = 100;
   localparam logic [RING_W-1:0] RING_MAX = 27'd67108864;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [RING_W-1:0]    req_request_bytes;
   logic [FENCE_W-1:0]   req_current_fence;
   logic [FENCE_W-1:0]   req_completed_fence;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [OFF_OUT_W-1:0] rsp_offset;
   logic [FENCE_W-1:0]   rsp_oldest_fence;
   logic                 csr_write_enable;
   logic [RING_W-1:0]    csr_write_data;

   fenced_ring_buffer_allocator #(
      .PENDING_ENTRIES(QUEUE_DEPTH),
      .OFFSET_BITS    (RING_W)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_request_bytes  (req_request_bytes),
      .req_current_fence  (req_current_fence),
      .req_completed_fence(req_completed_fence),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_offset         (rsp_offset),
      .rsp_oldest_fence   (rsp_oldest_fence),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   class alloc_scoreboard;
      typedef struct packed {
         logic [STATUS_W-1:0]  status;
         logic [OFF_OUT_W-1:0] offset;
         logic [FENCE_W-1:0]   oldest;
      } alloc_result_type;

      alloc_result_type     expected_q[$];
      logic [RING_W-1:0]    ring_size, head_pos, tail_pos, used_bytes;
      logic [FENCE_W-1:0]   last_done;
      logic [FENCE_W-1:0]   fence_keys[QUEUE_DEPTH];
      logic [RING_W-1:0]    byte_counts[QUEUE_DEPTH];
      logic [3:0]           rd_ptr;
      logic [4:0]           count;
      int                   errors;
      int                   checked;
      int                   status_seen[8];

      function new();
         ring_size = '0;
         last_done = '0;
         errors    = 0;
         checked   = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_ring();
      endfunction

      function void clear_ring();
         head_pos   = '0;
         tail_pos   = '0;
         used_bytes = '0;
         rd_ptr     = '0;
         count      = '0;
      endfunction

      function void write_ring_size(logic [RING_W-1:0] value);
         ring_size = value;
         clear_ring();
      endfunction

      function logic [3:0] newest_slot();
         return rd_ptr + count[3:0] - 4'd1;
      endfunction

      // Same fence as the newest entry folds into it
      function bit joins_newest(logic [FENCE_W-1:0] key);
         return count != 0 && fence_keys[newest_slot()] == key;
      endfunction

      function bit has_room(logic [FENCE_W-1:0] key);
         return joins_newest(key) || count < QUEUE_DEPTH;
      endfunction

      function void charge(logic [FENCE_W-1:0] key, logic [RING_W-1:0] nbytes);
         logic [3:0] slot;
         if (joins_newest(key)) begin
            slot = newest_slot();
            byte_counts[slot] = byte_counts[slot] + nbytes;
         end else begin
            slot = rd_ptr + count[3:0];
            fence_keys[slot]  = key;
            byte_counts[slot] = nbytes;
            count = count + 5'd1;
         end
      endfunction

      function void retire_completed(logic [FENCE_W-1:0] done_fence);
         logic [RING_W-1:0] nbytes;
         logic [RING_W:0]   sum;
         if (done_fence <= last_done) return;
         last_done = done_fence;
         while (count != 0) begin
            nbytes = byte_counts[rd_ptr];
            if (fence_keys[rd_ptr] > done_fence) break;
            sum = {1'b0, head_pos} + nbytes;
            head_pos   = (ring_size == 0) ? '0 : RING_W'(sum % ring_size);
            used_bytes = (nbytes > used_bytes) ? '0 : used_bytes - nbytes;
            rd_ptr = rd_ptr + 4'd1;
            count  = count - 5'd1;
         end
      endfunction

      function logic [STATUS_W-1:0] try_allocate(input logic [RING_W-1:0] nbytes,
                                                 input logic [FENCE_W-1:0] key,
                                                 output logic [RING_W-1:0] start);
         logic [RING_W-1:0] pad;
         start = '0;
         if (nbytes == 0 || ring_size == 0 || nbytes > ring_size)
            return frba_pkg::STAT_BAD_SIZE;
         if ({1'b0, tail_pos} + nbytes > {1'b0, ring_size}) begin
            if (head_pos == 0) return frba_pkg::STAT_WRAP_BLK;
            if (!has_room(key)) return frba_pkg::STAT_QFULL;
            // padding to the ring end is charged even if the request fails below
            pad = (ring_size > tail_pos) ? ring_size - tail_pos : '0;
            charge(key, pad);
            used_bytes = used_bytes + pad;
            tail_pos   = '0;
         end
         if ({1'b0, used_bytes} + nbytes > {1'b0, ring_size}) return frba_pkg::STAT_FULL;
         if (tail_pos < head_pos && {1'b0, tail_pos} + nbytes > {1'b0, head_pos})
            return frba_pkg::STAT_OVERLAP;
         if (!has_room(key)) return frba_pkg::STAT_QFULL;
         start      = tail_pos;
         tail_pos   = tail_pos + nbytes;
         used_bytes = used_bytes + nbytes;
         charge(key, nbytes);
         return frba_pkg::STAT_OK;
      endfunction

      function void note_request(logic [RING_W-1:0] nbytes, logic [FENCE_W-1:0] key,
                                 logic [FENCE_W-1:0] done_fence);
         alloc_result_type  res;
         logic [RING_W-1:0] start;
         retire_completed(done_fence);
         res.status = try_allocate(nbytes, key, start);
         res.offset = start[OFF_OUT_W-1:0];
         res.oldest = (count != 0) ? fence_keys[rd_ptr] : '0;
         status_seen[res.status]++;
         expected_q = {expected_q, res};
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [OFF_OUT_W-1:0] offset,
                                 logic [FENCE_W-1:0] oldest);
         alloc_result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing pending: status %0d offset %0d oldest %h",
                     $time, status, offset, oldest);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         checked++;
         if (status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
            errors++;
         end
         if (offset !== exp_res.offset) begin
            $display("%0t: offset expected %0d actual %0d", $time, exp_res.offset, offset);
            errors++;
         end
         if (oldest !== exp_res.oldest) begin
            $display("%0t: oldest_fence expected %h actual %h", $time, exp_res.oldest, oldest);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   alloc_scoreboard sb;
   int              burst_left = 0;
   int              n_sent = 0;
   int              n_settings = 0;
   int              idle_cycles = 0;
   int              stall_mode = 0;
   int              stall_tick = 0;

   // Response side: check transfers, stall on a pattern that changes mode, watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
         rsp_stall   <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_offset, rsp_oldest_fence);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, %0d responses outstanding", $time, sb.outstanding());
            $display("DONE: errors detected");
            $finish;
         end
         stall_tick <= stall_tick + 1;
         if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick % 8 < 5);
         endcase
      end
   end

   task automatic send_request(input logic [RING_W-1:0] nbytes, input logic [FENCE_W-1:0] key,
                               input logic [FENCE_W-1:0] done_fence);
      req_valid           <= 1'b1;
      req_request_bytes   <= nbytes;
      req_current_fence   <= key;
      req_completed_fence <= done_fence;
      do @(posedge clock); while (req_stall);
      sb.note_request(nbytes, key, done_fence);
      n_sent++;
   endtask

   // Bursts of back-to-back transfers separated by random gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_ring(input logic [RING_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_ring_size(value);
      csr_write_enable <= 1'b0;
      n_settings++;
   endtask

   function automatic logic [RING_W-1:0] pick_size(logic [RING_W-1:0] ring);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 6) return ring + RING_W'($urandom_range(1, 100));
      if (r < 8) return RING_W'($urandom);
      if (r < 20 || ring < 6) return RING_W'($urandom_range(1, (ring == 0) ? 1 : ring));
      return RING_W'($urandom_range(1, ring / 6));
   endfunction

   // Mostly well-formed traffic: rising fences, several requests per fence, completion lagging
   task automatic run_phase(input logic [RING_W-1:0] ring, input int n_items);
      logic [FENCE_W-1:0] fence;
      logic [FENCE_W-1:0] done_fence;
      logic [FENCE_W-1:0] key;
      int unsigned        lag;
      set_ring(ring);
      fence      = sb.last_done + $urandom_range(1, 4);
      done_fence = sb.last_done;
      repeat (n_items) begin
         if ($urandom_range(0, 99) < 5) begin
            // out-of-order key and a stale completion value
            key = fence - ((fence > 40) ? $urandom_range(0, 40) : 0);
            send_request(pick_size(ring), key, done_fence >> 1);
         end else begin
            if ($urandom_range(0, 2) == 0) fence = fence + $urandom_range(1, 3);
            if ($urandom_range(0, 99) < 35) begin
               lag = $urandom_range(0, 20);
               if (fence > lag && fence - lag > done_fence) done_fence = fence - lag;
            end
            send_request(pick_size(ring), fence, done_fence);
         end
         pace();
      end
   endtask

   initial begin
      sb                  = new();
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_request_bytes   <= '0;
      req_current_fence   <= '0;
      req_completed_fence <= '0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: size checks, merge, wrap blocked, padding kept on failure
      send_request(27'd10, 64'd1, 64'd0);        // ring still zero
      set_ring(27'd100);
      send_request(27'd0, 64'd1, 64'd0);
      send_request(27'd101, 64'd1, 64'd0);
      send_request('1, 64'd1, 64'd0);
      send_request(27'd60, 64'd1, 64'd0);
      send_request(27'd30, 64'd1, 64'd0);         // same fence, merges
      send_request(27'd20, 64'd2, 64'd0);         // wrap with head at zero
      send_request(27'd20, 64'd2, 64'd1);         // reclaim, pad and wrap
      send_request(27'd70, 64'd3, 64'd1);
      send_request(27'd20, 64'd4, 64'd1);         // pad charged, then full

      // Directed: fill the fence queue, then hit queue-full on wrap and on allocate
      set_ring(27'd200);
      for (int i = 0; i < QUEUE_DEPTH; i++) send_request(27'd10, 64'(10 + i), 64'd1);
      send_request(27'd10, 64'd26, 64'd10);
      send_request(27'd40, 64'd27, 64'd10);
      send_request(27'd20, 64'd27, 64'd10);
      send_request(27'd10, 64'd5, 64'd30);        // drains queue, key goes backwards
      send_request(27'd10, 64'd3, 64'd4);

      run_phase(27'd0, 20);
      run_phase(27'd1, 60);
      run_phase(RING_MAX, 80);
      repeat (10) begin
         case ($urandom_range(0, 3))
            0: run_phase(RING_W'($urandom_range(2, 64)), 100);
            1: run_phase(RING_W'($urandom_range(65, 4096)), 100);
            2: run_phase(RING_W'($urandom_range(4097, 1 << 20)), 100);
            default: run_phase(RING_W'($urandom_range(1 << 20, 1 << 26)), 100);
         endcase
      end

      // Noise last: arbitrary fences would otherwise stall reclaim for later traffic
      set_ring(RING_W'($urandom_range(65, 4096)));
      repeat (60) begin
         send_request(($urandom_range(0, 1) == 0) ? RING_W'($urandom) : pick_size(sb.ring_size),
                      {$urandom, $urandom}, {$urandom, $urandom});
         pace();
      end
      send_request(27'd1, '1, 64'd0);
      send_request(27'd1, 64'd0, '1);
      send_request(sb.ring_size, '1, '1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d ring sizes, %0d responses checked",
               n_sent, n_settings, sb.checked);
      $display("Status mix: ok %0d, bad size %0d, wrap blocked %0d, full %0d,",
               sb.status_seen[frba_pkg::STAT_OK], sb.status_seen[frba_pkg::STAT_BAD_SIZE],
               sb.status_seen[frba_pkg::STAT_WRAP_BLK], sb.status_seen[frba_pkg::STAT_FULL],
               " overlap %0d, qfull %0d",
               sb.status_seen[frba_pkg::STAT_OVERLAP], sb.status_seen[frba_pkg::STAT_QFULL]);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
sv/frba_pkg.sv
sv/frba_front.sv
sv/frba_fifo.sv
sv/frba_rem.sv
sv/frba_back.sv
sv/fenced_ring_buffer_allocator.sv
bench/fenced_ring_buffer_allocator_tb.sv
